// ----- hdl/consistent_hash_ring_table_defines.svh -----
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_defines
// assertion macros shared by the ring table rtl
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_TABLE_DEFINES_SVH
`define CONSISTENT_HASH_RING_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

`define CHRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define CHRT_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define CHRT_ASSERT(lbl, prop, msg)

`define CHRT_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- hdl/chrt_pkg.sv -----
// ----------------------------------------------------------------------------
// chrt_pkg
// types and constants shared by the ring table cells and top level
// ----------------------------------------------------------------------------
package chrt_pkg;

   localparam int KEY_W            = 32;
   localparam int TAG_W            = 16;
   localparam int COUNT_W          = 9;
   localparam int RING_ENTRIES_DEF = 256;
   localparam int TAG_BITS_DEF     = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2,
      STS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic   active;
      op_type op;
      logic   hit;
      logic   free_ok;
      logic   least_ok;
      logic   succ_ok;
   } tok_ctl_type;

endpackage

// ----- hdl/chrt_cell.sv -----
// ----------------------------------------------------------------------------
// chrt_cell
// one ring entry plus one stage of the search token that walks the chain
// ----------------------------------------------------------------------------
module chrt_cell #(
   parameter int IDX_BITS = $clog2(chrt_pkg::RING_ENTRIES_DEF),
   parameter int TAG_BITS = chrt_pkg::TAG_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [IDX_BITS-1:0]        cell_idx,
   input  chrt_pkg::tok_ctl_type      ctl_i,
   input  logic [chrt_pkg::KEY_W-1:0] key_i,
   input  logic [TAG_BITS-1:0]        tag_i,
   input  logic [TAG_BITS-1:0]        hit_tag_i,
   input  logic [IDX_BITS-1:0]        free_idx_i,
   input  logic [chrt_pkg::KEY_W-1:0] least_key_i,
   input  logic [TAG_BITS-1:0]        least_tag_i,
   input  logic [chrt_pkg::KEY_W-1:0] succ_key_i,
   input  logic [TAG_BITS-1:0]        succ_tag_i,
   output chrt_pkg::tok_ctl_type      ctl_o,
   output logic [chrt_pkg::KEY_W-1:0] key_o,
   output logic [TAG_BITS-1:0]        tag_o,
   output logic [TAG_BITS-1:0]        hit_tag_o,
   output logic [IDX_BITS-1:0]        free_idx_o,
   output logic [chrt_pkg::KEY_W-1:0] least_key_o,
   output logic [TAG_BITS-1:0]        least_tag_o,
   output logic [chrt_pkg::KEY_W-1:0] succ_key_o,
   output logic [TAG_BITS-1:0]        succ_tag_o,
   input  logic                       wr_en,
   input  logic [IDX_BITS-1:0]        wr_idx,
   input  logic [chrt_pkg::KEY_W-1:0] wr_key,
   input  logic [TAG_BITS-1:0]        wr_tag
);

   logic                       valid_ff, valid_in;
   logic [chrt_pkg::KEY_W-1:0] ent_key_ff, ent_key_in;
   logic [TAG_BITS-1:0]        ent_tag_ff, ent_tag_in;

   chrt_pkg::tok_ctl_type      ctl_ff, ctl_in;
   logic [chrt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0]        tag_ff, tag_in;
   logic [TAG_BITS-1:0]        hit_tag_ff, hit_tag_in;
   logic [IDX_BITS-1:0]        free_idx_ff, free_idx_in;
   logic [chrt_pkg::KEY_W-1:0] least_key_ff, least_key_in;
   logic [TAG_BITS-1:0]        least_tag_ff, least_tag_in;
   logic [chrt_pkg::KEY_W-1:0] succ_key_ff, succ_key_in;
   logic [TAG_BITS-1:0]        succ_tag_ff, succ_tag_in;

   logic match;
   logic wr_hit;

   always_comb begin
      match  = ctl_i.active && valid_ff && (ent_key_ff == key_i);
      wr_hit = wr_en && (wr_idx == cell_idx);

      // entry update
      valid_in   = valid_ff;
      ent_key_in = ent_key_ff;
      ent_tag_in = ent_tag_ff;
      if (wr_hit) begin
         valid_in   = 1'b1;
         ent_key_in = wr_key;
         ent_tag_in = wr_tag;
      end
      if (match && (ctl_i.op == chrt_pkg::OP_INSERT)) begin
         ent_tag_in = tag_i;
      end
      if (match && (ctl_i.op == chrt_pkg::OP_REMOVE)) begin
         valid_in = 1'b0;
      end

      // token stage
      ctl_in       = ctl_i;
      key_in       = key_i;
      tag_in       = tag_i;
      hit_tag_in   = hit_tag_i;
      free_idx_in  = free_idx_i;
      least_key_in = least_key_i;
      least_tag_in = least_tag_i;
      succ_key_in  = succ_key_i;
      succ_tag_in  = succ_tag_i;
      if (match) begin
         ctl_in.hit = 1'b1;
         hit_tag_in = ent_tag_ff;
      end
      if (!ctl_i.free_ok && !valid_ff) begin
         ctl_in.free_ok = 1'b1;
         free_idx_in    = cell_idx;
      end
      if (valid_ff && (!ctl_i.least_ok || (ent_key_ff < least_key_i))) begin
         ctl_in.least_ok = 1'b1;
         least_key_in    = ent_key_ff;
         least_tag_in    = ent_tag_ff;
      end
      if (valid_ff && (ent_key_ff > key_i) &&
          (!ctl_i.succ_ok || (ent_key_ff < succ_key_i))) begin
         ctl_in.succ_ok = 1'b1;
         succ_key_in    = ent_key_ff;
         succ_tag_in    = ent_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctl_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_key_ff   <= ent_key_in;
      ent_tag_ff   <= ent_tag_in;
      key_ff       <= key_in;
      tag_ff       <= tag_in;
      hit_tag_ff   <= hit_tag_in;
      free_idx_ff  <= free_idx_in;
      least_key_ff <= least_key_in;
      least_tag_ff <= least_tag_in;
      succ_key_ff  <= succ_key_in;
      succ_tag_ff  <= succ_tag_in;
   end

   assign ctl_o       = ctl_ff;
   assign key_o       = key_ff;
   assign tag_o       = tag_ff;
   assign hit_tag_o   = hit_tag_ff;
   assign free_idx_o  = free_idx_ff;
   assign least_key_o = least_key_ff;
   assign least_tag_o = least_tag_ff;
   assign succ_key_o  = succ_key_ff;
   assign succ_tag_o  = succ_tag_ff;

endmodule

// ----- hdl/consistent_hash_ring_table.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_ring_table
// Bounded consistent-hash ring of 32-bit positions, each mapped to a node
// tag, with insert, remove, exact get and successor lookup (wrapping to the
// smallest position). The table is a chain of RING_ENTRIES cells; each
// request beat becomes a search token that moves one cell per clock. The
// outcome is taken when the token leaves the last cell and is held in the
// output state until the response side can take it; a new request is taken
// only after the previous response beat is issued. One request is worked
// on at a time and each gives exactly one response beat, in order. Status
// is ok, key not found, table full or ring empty; entry_count is the
// occupancy after the operation. Reset empties the ring at once, with no
// clearing pass.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_table_defines.svh"

module consistent_hash_ring_table #(
   parameter int RING_ENTRIES = chrt_pkg::RING_ENTRIES_DEF,
   parameter int TAG_BITS     = chrt_pkg::TAG_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [chrt_pkg::KEY_W-1:0]   req_key_hash,
   input  logic [chrt_pkg::TAG_W-1:0]   req_node_tag,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [chrt_pkg::KEY_W-1:0]   rsp_found_hash,
   output logic [chrt_pkg::TAG_W-1:0]   rsp_found_tag,
   output logic [chrt_pkg::COUNT_W-1:0] rsp_entry_count
);

   localparam int IDX_BITS = $clog2(RING_ENTRIES);
   localparam int OCC_BITS = $clog2(RING_ENTRIES + 1);

   chrt_pkg::tok_ctl_type      tok_ctl       [RING_ENTRIES+1];
   logic [chrt_pkg::KEY_W-1:0] tok_key       [RING_ENTRIES+1];
   logic [TAG_BITS-1:0]        tok_tag       [RING_ENTRIES+1];
   logic [TAG_BITS-1:0]        tok_hit_tag   [RING_ENTRIES+1];
   logic [IDX_BITS-1:0]        tok_free_idx  [RING_ENTRIES+1];
   logic [chrt_pkg::KEY_W-1:0] tok_least_key [RING_ENTRIES+1];
   logic [TAG_BITS-1:0]        tok_least_tag [RING_ENTRIES+1];
   logic [chrt_pkg::KEY_W-1:0] tok_succ_key  [RING_ENTRIES+1];
   logic [TAG_BITS-1:0]        tok_succ_tag  [RING_ENTRIES+1];
   logic [RING_ENTRIES-1:0]    tok_active;

   chrt_pkg::state_type        state_ff, state_in;
   logic [OCC_BITS-1:0]        occ_ff, occ_in;
   chrt_pkg::status_type       res_status_ff, res_status_in;
   logic [chrt_pkg::KEY_W-1:0] res_hash_ff, res_hash_in;
   logic [chrt_pkg::TAG_W-1:0] res_tag_ff, res_tag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   chrt_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [chrt_pkg::KEY_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [chrt_pkg::TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [OCC_BITS-1:0]        rsp_count_ff, rsp_count_in;

   logic                       inject;
   logic                       wr_en;
   chrt_pkg::tok_ctl_type      inj_ctl;
   chrt_pkg::tok_ctl_type      exit_ctl;
   chrt_pkg::status_type       c_status;
   logic [chrt_pkg::KEY_W-1:0] c_hash;
   logic [TAG_BITS-1:0]        c_tag;
   logic [OCC_BITS-1:0]        c_occ;
   logic                       c_write;

   // token entering the chain
   always_comb begin
      inj_ctl        = '0;
      inj_ctl.active = inject;
      inj_ctl.op     = chrt_pkg::op_type'(req_opcode);
   end

   assign tok_ctl[0]       = inj_ctl;
   assign tok_key[0]       = req_key_hash;
   assign tok_tag[0]       = TAG_BITS'(req_node_tag);
   assign tok_hit_tag[0]   = '0;
   assign tok_free_idx[0]  = '0;
   assign tok_least_key[0] = '0;
   assign tok_least_tag[0] = '0;
   assign tok_succ_key[0]  = '0;
   assign tok_succ_tag[0]  = '0;

   for (genvar i = 0; i < RING_ENTRIES; i++) begin : g_cell
      chrt_cell #(
         .IDX_BITS (IDX_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_BITS'(i)),
         .ctl_i       (tok_ctl[i]),
         .key_i       (tok_key[i]),
         .tag_i       (tok_tag[i]),
         .hit_tag_i   (tok_hit_tag[i]),
         .free_idx_i  (tok_free_idx[i]),
         .least_key_i (tok_least_key[i]),
         .least_tag_i (tok_least_tag[i]),
         .succ_key_i  (tok_succ_key[i]),
         .succ_tag_i  (tok_succ_tag[i]),
         .ctl_o       (tok_ctl[i+1]),
         .key_o       (tok_key[i+1]),
         .tag_o       (tok_tag[i+1]),
         .hit_tag_o   (tok_hit_tag[i+1]),
         .free_idx_o  (tok_free_idx[i+1]),
         .least_key_o (tok_least_key[i+1]),
         .least_tag_o (tok_least_tag[i+1]),
         .succ_key_o  (tok_succ_key[i+1]),
         .succ_tag_o  (tok_succ_tag[i+1]),
         .wr_en       (wr_en),
         .wr_idx      (tok_free_idx[RING_ENTRIES]),
         .wr_key      (tok_key[RING_ENTRIES]),
         .wr_tag      (tok_tag[RING_ENTRIES])
      );
      assign tok_active[i] = tok_ctl[i+1].active;
   end

   assign exit_ctl = tok_ctl[RING_ENTRIES];

   // outcome of the token leaving the last cell
   always_comb begin
      c_status = chrt_pkg::STS_OK;
      c_hash   = '0;
      c_tag    = '0;
      c_occ    = occ_ff;
      c_write  = 1'b0;
      case (exit_ctl.op)
         chrt_pkg::OP_INSERT: begin
            if (!exit_ctl.hit) begin
               if (exit_ctl.free_ok) begin
                  c_write = 1'b1;
                  c_occ   = occ_ff + OCC_BITS'(1);
               end else begin
                  c_status = chrt_pkg::STS_FULL;
               end
            end
         end
         chrt_pkg::OP_REMOVE: begin
            if (exit_ctl.hit) begin
               c_occ = occ_ff - OCC_BITS'(1);
            end else begin
               c_status = chrt_pkg::STS_NOT_FOUND;
            end
         end
         chrt_pkg::OP_GET: begin
            if (exit_ctl.hit) begin
               c_hash = tok_key[RING_ENTRIES];
               c_tag  = tok_hit_tag[RING_ENTRIES];
            end else begin
               c_status = chrt_pkg::STS_NOT_FOUND;
            end
         end
         chrt_pkg::OP_NEXT: begin
            if (!exit_ctl.least_ok) begin
               c_status = chrt_pkg::STS_EMPTY;
            end else if (exit_ctl.succ_ok) begin
               c_hash = tok_succ_key[RING_ENTRIES];
               c_tag  = tok_succ_tag[RING_ENTRIES];
            end else begin
               c_hash = tok_least_key[RING_ENTRIES];
               c_tag  = tok_least_tag[RING_ENTRIES];
            end
         end
         default: begin
            c_status = chrt_pkg::STS_OK;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      res_status_in = res_status_ff;
      res_hash_in   = res_hash_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      req_stall     = 1'b1;
      inject        = 1'b0;
      wr_en         = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         chrt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               inject   = 1'b1;
               state_in = chrt_pkg::S_SCAN;
            end
         end
         chrt_pkg::S_SCAN: begin
            if (exit_ctl.active) begin
               wr_en         = c_write;
               occ_in        = c_occ;
               res_status_in = c_status;
               res_hash_in   = c_hash;
               res_tag_in    = chrt_pkg::TAG_W'(c_tag);
               state_in      = chrt_pkg::S_OUT;
            end
         end
         chrt_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hash_in   = res_hash_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_count_in  = occ_ff;
               state_in      = chrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chrt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chrt_pkg::S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_hash_ff   <= res_hash_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_hash  = rsp_hash_ff;
   assign rsp_found_tag   = rsp_tag_ff;
   assign rsp_entry_count = chrt_pkg::COUNT_W'(rsp_count_ff);

   // checks
   `CHRT_ASSERT(a_one_token, $onehot0(tok_active), "more than one token in the cell chain")
   `CHRT_ASSERT(a_occ_bound, occ_ff <= OCC_BITS'(RING_ENTRIES), "occupancy above table size")
   `CHRT_ASSERT(a_exit_in_scan, !exit_ctl.active || (state_ff == chrt_pkg::S_SCAN), "token left chain outside scan")
   `CHRT_ASSERT_NEXT(a_accept_scan, req_valid && !req_stall, (state_ff == chrt_pkg::S_SCAN) && tok_active[0], "accepted beat did not enter the chain")

endmodule
